>>> hw/rtl/sa_pkg.sv
// Shared constants, beat types and pipeline sideband for the spectral absorbance block.
`default_nettype none
package sa_pkg;

	// Raw converter count width.
	localparam int INTENSITY_BITS = 16;
	localparam int NUM_W  = INTENSITY_BITS + 1;
	localparam int EXP_W  = $clog2(NUM_W);
	localparam int FRAC_W = 32;
	localparam int LOG_W  = EXP_W + FRAC_W;

	localparam int PATH_W = 10;
	localparam logic [PATH_W-1:0] PATH_RESET = PATH_W'(100);

	localparam logic [NUM_W-1:0] OFFSET_COUNTS = NUM_W'(10);
	localparam logic [NUM_W-1:0] UNIT_DIVISOR  = NUM_W'(1);

	// Scaling chain: Q32 log2 -> Q28 -> times log10(2) in Q30 -> Q40 -> Q16.
	localparam int TRUNC_SHIFT = 4;
	localparam int D28_W  = LOG_W - TRUNC_SHIFT;
	localparam int LO_W   = (D28_W + 1) / 2;
	localparam int HI_W   = D28_W - LO_W;
	localparam int C_W    = 29;
	localparam logic [C_W-1:0] LOG10_2_Q30 = C_W'(323228497);
	localparam int P58_W  = D28_W + C_W;
	localparam int DROP_SHIFT = 18;
	localparam int X18_W  = P58_W - DROP_SHIFT;
	localparam int X40_W  = X18_W + 7;
	localparam logic [X40_W-1:0] HUNDRED = X40_W'(100);
	localparam int M_W    = X40_W + 1;
	localparam int ROUND_SHIFT = 23;
	localparam int Q_SHIFT = 24;
	localparam int T_W    = M_W - Q_SHIFT;

	localparam int OUT_W = 26;
	localparam logic [T_W-1:0] OUT_MAX_MAG = T_W'(33554431);
	localparam logic [T_W-1:0] OUT_MIN_MAG = T_W'(33554432);
	localparam logic signed [OUT_W-1:0] OUT_MAX = 26'sh1FFFFFF;
	localparam logic signed [OUT_W-1:0] OUT_MIN = 26'sh2000000;

	// Input register, normalize stage, one stage per log bit, four scaling
	// stages, one stage per quotient bit and the output register.
	localparam int LATENCY = 1 + 1 + FRAC_W + 4 + T_W + 1;

	typedef struct packed {
		logic [INTENSITY_BITS-1:0] blank_intensity;
		logic [INTENSITY_BITS-1:0] sample_intensity;
		logic                      sample_present;
		logic                      last;
	} in_beat_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] absorbance;
		logic                    last_res;
	} out_beat_t;

	typedef struct packed {
		logic valid;
		logic last;
		logic neg;
	} side_t;

endpackage
`default_nettype wire

>>> hw/rtl/sa_log2.sv
// Two-lane pipelined base-2 logarithm by repeated squaring, one result bit per stage.
`default_nettype none
module sa_log2 (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic [sa_pkg::NUM_W-1:0]   num,
	input  wire logic [sa_pkg::NUM_W-1:0]   den,
	input  wire sa_pkg::side_t              side_in,
	output logic      [sa_pkg::LOG_W-1:0]   log_num,
	output logic      [sa_pkg::LOG_W-1:0]   log_den,
	output sa_pkg::side_t                   side_out
);

	localparam int STEPS = sa_pkg::FRAC_W;

	logic [31:0]              y_s  [0:STEPS][0:1];
	logic [STEPS-1:0]         fr_s [0:STEPS][0:1];
	logic [sa_pkg::EXP_W-1:0] ex_s [0:STEPS][0:1];
	sa_pkg::side_t            side_s [0:STEPS];

	function automatic logic [sa_pkg::EXP_W-1:0] msb_index(input logic [sa_pkg::NUM_W-1:0] x);
		logic [sa_pkg::EXP_W-1:0] idx;
		idx = '0;
		for (int i = 0; i < sa_pkg::NUM_W; i++) begin
			if (x[i]) begin
				idx = sa_pkg::EXP_W'(i);
			end
		end
		return idx;
	endfunction

	// Normalize each operand so that its leading one sits at bit 31.
	for (genvar l = 0; l < 2; l++) begin : g_norm
		logic [sa_pkg::NUM_W-1:0] x;
		logic [sa_pkg::EXP_W-1:0] idx;
		assign x   = (l == 0) ? num : den;
		assign idx = msb_index(x);
		always_ff @(posedge clk) begin
			y_s[0][l]  <= 32'(x) << (5'd31 - 5'(idx));
			fr_s[0][l] <= '0;
			ex_s[0][l] <= idx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s[0] <= '0;
		end else begin
			side_s[0] <= side_in;
		end
	end

	for (genvar g = 0; g < STEPS; g++) begin : g_step
		for (genvar l = 0; l < 2; l++) begin : g_lane
			logic [63:0] sq;
			logic [32:0] t;
			assign sq = y_s[g][l] * y_s[g][l];
			assign t  = sq[63:31];
			always_ff @(posedge clk) begin
				y_s[g+1][l]  <= t[32] ? t[32:1] : t[31:0];
				fr_s[g+1][l] <= {fr_s[g][l][STEPS-2:0], t[32]};
				ex_s[g+1][l] <= ex_s[g][l];
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				side_s[g+1] <= '0;
			end else begin
				side_s[g+1] <= side_s[g];
			end
		end
	end

	assign log_num  = {ex_s[STEPS][0], fr_s[STEPS][0]};
	assign log_den  = {ex_s[STEPS][1], fr_s[STEPS][1]};
	assign side_out = side_s[STEPS];

endmodule
`default_nettype wire

>>> hw/rtl/sa_scale.sv
// Four-stage scaling of the log2 difference to a rounded, path-scaled dividend.
`default_nettype none
module sa_scale (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic [sa_pkg::LOG_W-1:0]  log_num,
	input  wire logic [sa_pkg::LOG_W-1:0]  log_den,
	input  wire sa_pkg::side_t             side_in,
	input  wire logic [sa_pkg::PATH_W-1:0] path,
	output logic      [sa_pkg::T_W-1:0]    dividend,
	output sa_pkg::side_t                  side_out
);

	logic [sa_pkg::LOG_W:0]        diff;
	logic [sa_pkg::LOG_W-1:0]      mag_s1;
	sa_pkg::side_t                 side_s1, side_s2, side_s3, side_s4;
	logic [sa_pkg::D28_W-1:0]      d28;
	logic [sa_pkg::LO_W+sa_pkg::C_W-1:0] plo_s2;
	logic [sa_pkg::HI_W+sa_pkg::C_W-1:0] phi_s2;
	logic [sa_pkg::P58_W-1:0]      p58;
	logic [sa_pkg::X18_W-1:0]      x18_s3;
	logic [sa_pkg::X40_W-1:0]      x40;
	logic [sa_pkg::M_W-1:0]        m;
	logic [sa_pkg::T_W-1:0]        t_s4;

	// All later truncations are toward zero, so the chain runs on the magnitude.
	assign diff = {1'b0, log_num} - {1'b0, log_den};
	assign d28  = mag_s1[sa_pkg::LOG_W-1:sa_pkg::TRUNC_SHIFT];
	assign p58  = (sa_pkg::P58_W'(phi_s2) << sa_pkg::LO_W) + sa_pkg::P58_W'(plo_s2);
	assign x40  = sa_pkg::X40_W'(x18_s3) * sa_pkg::HUNDRED;
	assign m    = sa_pkg::M_W'(x40) + (sa_pkg::M_W'(path) << sa_pkg::ROUND_SHIFT);

	always_ff @(posedge clk) begin
		mag_s1 <= diff[sa_pkg::LOG_W] ? sa_pkg::LOG_W'(-diff) : diff[sa_pkg::LOG_W-1:0];
		plo_s2 <= sa_pkg::LO_W'(d28[sa_pkg::LO_W-1:0]) * sa_pkg::LOG10_2_Q30;
		phi_s2 <= sa_pkg::HI_W'(d28[sa_pkg::D28_W-1:sa_pkg::LO_W]) * sa_pkg::LOG10_2_Q30;
		x18_s3 <= p58[sa_pkg::P58_W-1:sa_pkg::DROP_SHIFT];
		t_s4   <= m[sa_pkg::M_W-1:sa_pkg::Q_SHIFT];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s1 <= '0;
			side_s2 <= '0;
			side_s3 <= '0;
			side_s4 <= '0;
		end else begin
			side_s1 <= '{valid: side_in.valid, last: side_in.last, neg: diff[sa_pkg::LOG_W]};
			side_s2 <= side_s1;
			side_s3 <= side_s2;
			side_s4 <= side_s3;
		end
	end

	assign dividend = t_s4;
	assign side_out = side_s4;

endmodule
`default_nettype wire

>>> hw/rtl/sa_div.sv
// Pipelined restoring divider by the path length, one quotient bit per stage.
`default_nettype none
module sa_div (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic [sa_pkg::T_W-1:0]    dividend,
	input  wire sa_pkg::side_t             side_in,
	input  wire logic [sa_pkg::PATH_W-1:0] path,
	output logic      [sa_pkg::T_W-1:0]    quotient,
	output sa_pkg::side_t                  side_out
);

	localparam int N = sa_pkg::T_W;

	logic [sa_pkg::PATH_W-1:0] rem_s  [0:N];
	logic [N-1:0]              quo_s  [0:N];
	logic [N-1:0]              dvd_s  [0:N];
	sa_pkg::side_t             side_s [0:N];

	assign rem_s[0]  = '0;
	assign quo_s[0]  = '0;
	assign dvd_s[0]  = dividend;
	assign side_s[0] = side_in;

	for (genvar k = 0; k < N; k++) begin : g_bit
		logic [sa_pkg::PATH_W:0] shifted;
		logic                    fits;
		logic [sa_pkg::PATH_W:0] reduced;
		assign shifted = {rem_s[k], dvd_s[k][N-1]};
		assign fits    = shifted >= {1'b0, path};
		assign reduced = shifted - {1'b0, path};
		always_ff @(posedge clk) begin
			rem_s[k+1] <= fits ? reduced[sa_pkg::PATH_W-1:0] : shifted[sa_pkg::PATH_W-1:0];
			quo_s[k+1] <= {quo_s[k][N-2:0], fits};
			dvd_s[k+1] <= dvd_s[k] << 1;
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				side_s[k+1] <= '0;
			end else begin
				side_s[k+1] <= side_s[k];
			end
		end
	end

	assign quotient = quo_s[N];
	assign side_out = side_s[N];

endmodule
`default_nettype wire

>>> hw/rtl/spectral_absorbance.sv
// Top level of the spectral absorbance pipeline: config register, stages and output register.
// A pixel accepted at a clock edge shows its result with done after it passes every stage.
// Throughput: one pixel per cycle; busy is always low and the receiver cannot stall.
// Depth comes from one squaring stage per log2 fraction bit and one stage per quotient bit.
// Reset clears every valid bit at once and loads the path register with 100 (10 mm).
// Beats already in flight when reset asserts are dropped; no clearing pass is needed.
`default_nettype none
module spectral_absorbance (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	output logic                           busy,
	input  wire sa_pkg::in_beat_t          pixel,
	output logic                           done,
	output sa_pkg::out_beat_t              result,
	input  wire logic                      cfg_we,
	input  wire logic [sa_pkg::PATH_W-1:0] cfg_wdata
);

	// Path register. A zero path is treated as one so that the divider never sees zero.
	logic [sa_pkg::PATH_W-1:0] path_q;
	logic [sa_pkg::PATH_W-1:0] path_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			path_q <= sa_pkg::PATH_RESET;
		end else if (cfg_we) begin
			path_q <= cfg_wdata;
		end
	end

	assign path_eff = (path_q == '0) ? sa_pkg::PATH_W'(1) : path_q;

	// The pipeline never stalls, so every start beat is taken.
	assign busy = 1'b0;

	// Input register: the beat and its valid bit enter together.
	sa_pkg::in_beat_t pixel_s1;
	logic             valid_s1;

	always_ff @(posedge clk) begin
		pixel_s1 <= pixel;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	// Numerator and denominator of the intensity ratio. Without a sample the
	// denominator is one, so the result is the log of the blank alone.
	logic [sa_pkg::NUM_W-1:0] num;
	logic [sa_pkg::NUM_W-1:0] den;
	sa_pkg::side_t            side_in;

	assign num = sa_pkg::NUM_W'(pixel_s1.blank_intensity) + sa_pkg::OFFSET_COUNTS;
	assign den = pixel_s1.sample_present
		? sa_pkg::NUM_W'(pixel_s1.sample_intensity) + sa_pkg::OFFSET_COUNTS
		: sa_pkg::UNIT_DIVISOR;
	assign side_in = '{valid: valid_s1, last: pixel_s1.last, neg: 1'b0};

	logic [sa_pkg::LOG_W-1:0] log_num;
	logic [sa_pkg::LOG_W-1:0] log_den;
	sa_pkg::side_t            side_log;

	sa_log2 u_log2 (
		.clk      (clk),
		.arst_n   (arst_n),
		.num      (num),
		.den      (den),
		.side_in  (side_in),
		.log_num  (log_num),
		.log_den  (log_den),
		.side_out (side_log)
	);

	// Difference of logs, scaling by log10(2) and by 100, and the rounding addend.
	logic [sa_pkg::T_W-1:0] dividend;
	sa_pkg::side_t          side_scale;

	sa_scale u_scale (
		.clk      (clk),
		.arst_n   (arst_n),
		.log_num  (log_num),
		.log_den  (log_den),
		.side_in  (side_log),
		.path     (path_eff),
		.dividend (dividend),
		.side_out (side_scale)
	);

	// Division by the path length gives the rounded magnitude in Q16.
	logic [sa_pkg::T_W-1:0] quotient;
	sa_pkg::side_t          side_div;

	sa_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.dividend (dividend),
		.side_in  (side_scale),
		.path     (path_eff),
		.quotient (quotient),
		.side_out (side_div)
	);

	// Output register: apply the sign and saturate to the 26-bit range.
	logic                           done_q;
	sa_pkg::out_beat_t              result_q;
	logic signed [sa_pkg::OUT_W-1:0] value;

	always_comb begin
		if (side_div.neg) begin
			value = (quotient > sa_pkg::OUT_MIN_MAG) ? sa_pkg::OUT_MIN
				: sa_pkg::OUT_W'(-quotient);
		end else begin
			value = (quotient > sa_pkg::OUT_MAX_MAG) ? sa_pkg::OUT_MAX
				: sa_pkg::OUT_W'(quotient);
		end
	end

	always_ff @(posedge clk) begin
		result_q <= '{absorbance: value, last_res: side_div.last};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= side_div.valid;
		end
	end

	assign done   = done_q;
	assign result = result_q;

	// Every accepted beat comes out after exactly the pipeline latency.
	a_latency_fwd: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##(sa_pkg::LATENCY) done)
		else $error("accepted beat did not complete on time");

	// No result appears without a matching beat accepted earlier.
	a_latency_back: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, sa_pkg::LATENCY))
		else $error("result without an accepted beat");

	// The last flag travels with its own beat.
	a_last_follows: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.last_res == $past(pixel.last, sa_pkg::LATENCY)))
		else $error("last flag out of step with its beat");

endmodule
`default_nettype wire

>>> test/testbench.sv
// Self-checking testbench for the spectral absorbance pipeline.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	// Abort limit. A correct run needs far fewer cycles, so this is generous.
	localparam int CYCLE_LIMIT = 400000;
	localparam int RANDOM_BEATS = 1850;

	// Predicts absorbance results and checks each one against the oldest pending beat.
	class absorbance_board;
		sa_pkg::out_beat_t pending[$];
		logic [sa_pkg::PATH_W-1:0] path;
		int mismatches;
		int checked;

		function new();
			path = sa_pkg::PATH_RESET;
			mismatches = 0;
			checked = 0;
		endfunction

		// Base-2 logarithm of x (x >= 1), 32 fraction bits, truncated.
		function automatic logic [63:0] log2_fixed(logic [63:0] x);
			logic [63:0] y;
			logic [63:0] frac;
			int e;
			frac = 0;
			e = 0;
			if (x == 0)
				x = 1;
			while (e < 31 && (x >> (e + 1)) != 0)
				e++;
			y = (x << (31 - e)) & 64'hFFFF_FFFF;
			for (int i = 0; i < 32; i++) begin
				y = (y * y) >> 31;
				frac = frac << 1;
				if (y >= 64'h1_0000_0000) begin
					y = y >> 1;
					frac[0] = 1'b1;
				end
			end
			return (64'(e) << 32) | frac;
		endfunction

		// Notes an accepted pixel and queues the absorbance it must produce.
		function void note_pixel(sa_pkg::in_beat_t p);
			logic [63:0] num, den, mag, q, divisor, pth;
			longint d32, d28, p58, x40;
			logic signed [sa_pkg::OUT_W-1:0] a;
			sa_pkg::out_beat_t r;
			num = 64'(p.blank_intensity) + 64'(sa_pkg::OFFSET_COUNTS);
			den = p.sample_present
				? 64'(p.sample_intensity) + 64'(sa_pkg::OFFSET_COUNTS) : 64'd1;
			d32 = longint'(log2_fixed(num)) - longint'(log2_fixed(den));
			// Signed divisions truncate toward zero, as the scaling chain does.
			d28 = d32 / 16;
			p58 = d28 * longint'(sa_pkg::LOG10_2_Q30);
			x40 = (p58 / 262144) * 100;
			pth = (path == 0) ? 64'd1 : 64'(path);
			divisor = pth << 24;
			mag = (x40 < 0) ? 64'(-x40) : 64'(x40);
			q = (mag + divisor / 2) / divisor;
			if (x40 < 0)
				a = (q > 64'd33554432) ? sa_pkg::OUT_MIN : -sa_pkg::OUT_W'(q);
			else
				a = (q > 64'd33554431) ? sa_pkg::OUT_MAX : sa_pkg::OUT_W'(q);
			r.absorbance = a;
			r.last_res = p.last;
			pending.push_back(r);
		endfunction

		// Checks one result beat against the oldest expectation.
		function void check_result(sa_pkg::out_beat_t got);
			sa_pkg::out_beat_t want;
			if (pending.size() == 0) begin
				fail_note("unexpected result", got, '0);
				return;
			end
			want = pending.pop_front();
			checked++;
			if (got.absorbance !== want.absorbance || got.last_res !== want.last_res)
				fail_note("mismatch", got, want);
		endfunction

		function void fail_note(string what, sa_pkg::out_beat_t got, sa_pkg::out_beat_t want);
			mismatches++;
			if (mismatches <= 10)
				$display("%s: absorbance %0d last %b, expected %0d last %b", what,
					got.absorbance, got.last_res, want.absorbance, want.last_res);
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	sa_pkg::in_beat_t pixel;
	logic done;
	sa_pkg::out_beat_t result;
	logic cfg_we;
	logic [sa_pkg::PATH_W-1:0] cfg_wdata;

	absorbance_board board;
	int cycles;
	bit quiet;   // When set, the sender never pauses.
	int beats_sent;

	spectral_absorbance dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.pixel(pixel),
		.done(done),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Results are taken at the rising edge that ends their one-cycle window.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (arst_n && done)
			board.check_result(result);
	end

	// The watchdog ends a hung run with the fail message.
	always @(posedge clk) begin
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("testbench NOT OK");
			$finish;
		end
	end

	// Presents one pixel beat and holds it until the block takes it. A random
	// idle pause sometimes comes first. The beat is set up on a falling edge;
	// acceptance is judged at the following rising edge.
	task automatic send_pixel(sa_pkg::in_beat_t p);
		int gap;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 8);
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start <= 1'b1;
		pixel <= p;
		forever begin
			@(posedge clk);
			if (!busy)
				break;
			@(negedge clk);
		end
		board.note_pixel(p);
		beats_sent++;
		@(negedge clk);
	endtask

	// Drops start, then waits for every pending result plus the pipeline depth,
	// which also covers anything still in flight before a register write.
	task automatic drain();
		start <= 1'b0;
		while (board.pending.size() != 0)
			@(negedge clk);
		repeat (sa_pkg::LATENCY + 4) @(negedge clk);
	endtask

	// Writes the path register; only called once the pipeline is empty.
	task automatic set_path(logic [sa_pkg::PATH_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		board.path = value;
	endtask

	function automatic sa_pkg::in_beat_t make_pixel(logic [15:0] b, logic [15:0] s,
		logic pr, logic l);
		sa_pkg::in_beat_t p;
		p.blank_intensity = b;
		p.sample_intensity = s;
		p.sample_present = pr;
		p.last = l;
		return p;
	endfunction

	// Random intensities: full range in two cases of five, opposite ends in two,
	// and in the last a sample anywhere from zero up to a blank of 1000 or more.
	function automatic sa_pkg::in_beat_t random_pixel();
		logic [15:0] b, s;
		case ($urandom_range(0, 4))
			0: begin
				b = 16'($urandom_range(0, 15));
				s = 16'($urandom_range(65520, 65535));
			end
			1: begin
				b = 16'($urandom_range(65520, 65535));
				s = 16'($urandom_range(0, 15));
			end
			2: begin
				b = 16'($urandom_range(1000, 65535));
				s = b - 16'($urandom_range(0, b));
			end
			default: begin
				b = 16'($urandom);
				s = 16'($urandom);
			end
		endcase
		return make_pixel(b, s, ($urandom_range(0, 7) != 0), ($urandom_range(0, 15) == 0));
	endfunction

	initial begin
		logic [sa_pkg::PATH_W-1:0] paths[5];
		sa_pkg::in_beat_t p;
		board = new();
		cycles = 0;
		quiet = 1'b0;
		beats_sent = 0;
		start = 1'b0;
		pixel = '0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		arst_n = 1'b0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed beats at the reset path: field extremes, the absent sample,
		// equal intensities, and both signs of the logarithm.
		send_pixel(make_pixel(16'h0000, 16'h0000, 1'b1, 1'b0));
		send_pixel(make_pixel(16'hFFFF, 16'hFFFF, 1'b1, 1'b1));
		send_pixel(make_pixel(16'hFFFF, 16'h0000, 1'b1, 1'b0));
		send_pixel(make_pixel(16'h0000, 16'hFFFF, 1'b1, 1'b0));
		send_pixel(make_pixel(16'h0000, 16'hFFFF, 1'b0, 1'b0));
		send_pixel(make_pixel(16'hFFFF, 16'h1234, 1'b0, 1'b1));
		send_pixel(make_pixel(16'h5555, 16'hAAAA, 1'b1, 1'b0));
		send_pixel(make_pixel(16'hAAAA, 16'h5555, 1'b1, 1'b1));
		send_pixel(make_pixel(16'd6, 16'd0, 1'b1, 1'b0));
		drain();

		// The smallest path scales the most; the absent sample gives the
		// largest positive value and the dark blank the most negative one.
		// A zero path is treated as one tenth of a millimeter.
		set_path(10'd1);
		send_pixel(make_pixel(16'hFFFF, 16'h0000, 1'b0, 1'b0));
		send_pixel(make_pixel(16'h0000, 16'hFFFF, 1'b1, 1'b1));
		send_pixel(make_pixel(16'hFFFF, 16'h0000, 1'b1, 1'b0));
		drain();
		set_path(10'd0);
		send_pixel(make_pixel(16'hFFFF, 16'h0000, 1'b0, 1'b0));
		send_pixel(make_pixel(16'h0000, 16'hFFFF, 1'b1, 1'b1));
		drain();
		set_path(10'd1023);
		send_pixel(make_pixel(16'hFFFF, 16'h0000, 1'b1, 1'b0));
		send_pixel(make_pixel(16'h0000, 16'hFFFF, 1'b1, 1'b1));
		send_pixel(make_pixel(16'd1, 16'd0, 1'b1, 1'b0));
		drain();

		// Random phases, each at its own path length; the last phase runs
		// back to back with no pauses.
		paths = '{10'd1000, 10'd1, 10'd512, 10'd100, 10'd0};
		for (int ph = 0; ph < 5; ph++) begin
			if (ph == 4)
				quiet = 1'b1;
			set_path(ph == 2 ? sa_pkg::PATH_W'($urandom_range(2, 999)) : paths[ph]);
			for (int i = 0; i < RANDOM_BEATS / 5; i++) begin
				p = random_pixel();
				send_pixel(p);
			end
			drain();
		end

		$display("%0d pixels sent, %0d results checked over several path lengths",
			beats_sent, board.checked);
		if (board.mismatches == 0 && board.pending.size() == 0) begin
			$display("testbench OK");
		end else begin
			$display("%0d mismatches, %0d results missing", board.mismatches,
				board.pending.size());
			$display("testbench NOT OK");
		end
		$finish;
	end
endmodule
